// ===== sv/per_source_connection_limit_table_unit_defines.svh =====
// Assertion macros shared by the connection limit table RTL.
`ifndef PER_SOURCE_CONNECTION_LIMIT_TABLE_UNIT_DEFINES_SVH
`define PER_SOURCE_CONNECTION_LIMIT_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PSCLT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PSCLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PSCLT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PSCLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/psclt_pkg.sv =====
// Shared types and constants of the per-source connection limit table.
package psclt_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 64;
   localparam int DEFAULT_COUNT_BITS    = 16;
   localparam int ADDR_BITS             = 32;
   localparam int SHOWN_BITS            = 16;
   localparam int LIMIT_BITS            = 16;

   typedef logic [1:0]            cmd_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [SHOWN_BITS-1:0] shown_type;
   typedef logic [LIMIT_BITS-1:0] limit_type;

   localparam cmd_type CMD_OPEN   = 2'd0;
   localparam cmd_type CMD_CLOSE  = 2'd1;
   localparam cmd_type CMD_CHECK  = 2'd2;
   localparam cmd_type CMD_UNUSED = 2'd3;

endpackage

// ===== sv/per_source_connection_limit_table_unit.sv =====
// Each accepted word is scanned against every table entry before its result word is registered and presented.
// A new word is stalled until the result of the previous one is registered; each event scans every table entry
// through the single read port of the entry memory, then writes the entry back when the command changes it.
// Reset: synchronous; a clearing pass over every table entry follows, during which
// no request word is taken (limit register writes are still accepted).
`include "per_source_connection_limit_table_unit_defines.svh"

module per_source_connection_limit_table_unit #(
   parameter int TABLE_ENTRIES = psclt_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int COUNT_BITS    = psclt_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  psclt_pkg::cmd_type    req_command,
   input  psclt_pkg::addr_type   req_remote_address,
   input  logic                  req_rule_matches,
   input  logic                  req_outer_accepted,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_reject,
   output logic                  rsp_found,
   output psclt_pkg::shown_type  rsp_current_count,
   output logic                  rsp_table_full,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  psclt_pkg::limit_type  csr_max_connections
);
   import psclt_pkg::*;

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENTRY_W = 1 + ADDR_BITS + COUNT_BITS;
   localparam int CMP_W   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
   localparam logic [IDX_W:0] NUM_ENTRIES = (IDX_W+1)'(TABLE_ENTRIES);
   localparam logic [IDX_W:0] LAST_ENTRY  = (IDX_W+1)'(TABLE_ENTRIES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [CMP_W-1:0] SHOWN_MAX = CMP_W'({SHOWN_BITS{1'b1}});

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // Entry word layout: valid at the top, then address, then count.
   logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W:0]   issue_ff, issue_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   cmd_type   cmd_ff;
   addr_type  addr_ff;
   logic      match_ff;
   logic      acc_ff;
   limit_type limit_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_reject_ff, rsp_found_ff, rsp_full_ff;
   shown_type rsp_count_ff;

   logic      req_fire;
   logic      done_fire;
   logic      rd_valid_bit;
   addr_type  rd_address;
   logic [COUNT_BITS-1:0] rd_count;

   logic                  res_reject, res_found, res_full, res_write, res_keep;
   logic [IDX_W-1:0]      res_slot;
   logic [COUNT_BITS-1:0] base_cnt, new_cnt;
   logic [CMP_W-1:0]      cnt_wide;
   shown_type             res_shown;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign rd_valid_bit = rd_data_ff[ENTRY_W-1];
   assign rd_address   = rd_data_ff[ENTRY_W-2 -: ADDR_BITS];
   assign rd_count     = rd_data_ff[COUNT_BITS-1:0];
   assign rd_addr      = (issue_ff < NUM_ENTRIES) ? issue_ff[IDX_W-1:0] : '0;

   // Result of the event once the scan has seen every entry.
   always_comb begin
      res_reject = 1'b0;
      res_found  = 1'b0;
      res_full   = 1'b0;
      res_write  = 1'b0;
      res_keep   = 1'b1;
      res_slot   = hit_idx_ff;
      base_cnt   = hit_cnt_ff;
      new_cnt    = '0;
      case (cmd_ff)
         CMD_OPEN: begin
            if (match_ff && !hit_ff) begin
               res_slot = free_idx_ff;
               base_cnt = '0;
            end
            if (hit_ff || (match_ff && free_ff)) begin
               res_found = 1'b1;
               new_cnt   = base_cnt;
               if (match_ff) begin
                  res_write = 1'b1;
                  if (acc_ff && (base_cnt != COUNT_MAX)) begin
                     new_cnt = base_cnt + 1'b1;
                  end
               end
            end
            res_full = match_ff && !hit_ff && !free_ff;
         end
         CMD_CLOSE: begin
            if (hit_ff) begin
               res_found = 1'b1;
               res_write = 1'b1;
               new_cnt   = (hit_cnt_ff != '0) ? hit_cnt_ff - 1'b1 : hit_cnt_ff;
               res_keep  = (new_cnt != '0);
            end
         end
         CMD_CHECK: begin
            if (hit_ff) begin
               res_found  = 1'b1;
               new_cnt    = hit_cnt_ff;
               res_reject = (CMP_W'(hit_cnt_ff) >= CMP_W'(limit_ff));
            end
         end
         default: begin
         end
      endcase
      cnt_wide  = CMP_W'(new_cnt);
      res_shown = (cnt_wide > SHOWN_MAX) ? SHOWN_MAX[SHOWN_BITS-1:0]
                                         : cnt_wide[SHOWN_BITS-1:0];
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = res_slot;
      mem_wdata = {res_keep, addr_ff, new_cnt};
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = issue_ff[IDX_W-1:0];
         mem_wdata = '0;
      end else if (done_fire && res_write) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      issue_in    = issue_ff;
      rd_pend_in  = 1'b0;
      rd_idx_in   = rd_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_cnt_in  = hit_cnt_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            issue_in = issue_ff + 1'b1;
            if (issue_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
               issue_in = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issue_ff < NUM_ENTRIES) begin
               issue_in   = issue_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = issue_ff[IDX_W-1:0];
            end
            if (rd_pend_ff) begin
               // Addresses are unique among valid entries, so the first hit is the only one.
               if (rd_valid_bit && (rd_address == addr_ff) && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_cnt_in = rd_count;
               end
               if (!rd_valid_bit && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_ENTRY[IDX_W-1:0]) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_max_connections;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_cnt_ff  <= hit_cnt_in;
      free_idx_ff <= free_idx_in;
      if (req_fire) begin
         cmd_ff   <= req_command;
         addr_ff  <= req_remote_address;
         match_ff <= req_rule_matches;
         acc_ff   <= req_outer_accepted;
      end
      if (done_fire) begin
         rsp_reject_ff <= res_reject;
         rsp_found_ff  <= res_found;
         rsp_count_ff  <= res_shown;
         rsp_full_ff   <= res_full;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reject        = rsp_reject_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_current_count = rsp_count_ff;
   assign rsp_table_full    = rsp_full_ff;

   `PSCLT_ASSERT_IMPLY(a_full_not_found, clock, reset, rsp_valid_ff, !(rsp_full_ff && rsp_found_ff), "table full reported together with a found entry")
   `PSCLT_ASSERT_IMPLY(a_reject_needs_found, clock, reset, rsp_valid_ff && rsp_reject_ff, rsp_found_ff, "reject reported without a found entry")
   `PSCLT_ASSERT_NEXT(a_done_exit, clock, reset, state_ff == ST_DONE, (state_ff == ST_DONE) || (state_ff == ST_IDLE), "unexpected state after result stage")
   `PSCLT_ASSERT_IMPLY(a_hit_free_distinct, clock, reset, hit_ff && free_ff, hit_idx_ff != free_idx_ff, "hit and free slot share an index")

endmodule
